### design/msat_pkg.sv
`default_nettype none

package msat_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int TAG_BITS   = 16;

  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [30:0] TIME_MAX          = 31'h7FFF_FFFF;
  localparam logic [30:0] DEFAULT_MAX_DELAY = 31'd2678400;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DELAY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                  latch_in;
    logic                  exec;
    logic                  scan_clear;
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_req;
  } dp_sts_t;

  // port tag (16 bit) to stored tag width, masking to TAG_BITS
  function automatic logic [TAG_BITS-1:0] tag_in(input logic [15:0] t);
    logic [31:0] w;
    w = 32'(t);
    return w[TAG_BITS-1:0];
  endfunction

  function automatic logic [15:0] tag_out(input logic [TAG_BITS-1:0] t);
    logic [31:0] w;
    w = 32'(t);
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

### design/msat_ctrl.sv
`default_nettype none

module msat_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire msat_pkg::dp_sts_t  sts,
  output msat_pkg::ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [msat_pkg::SLOT_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.rd_addr   = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = '0;
        state_nxt = sts.scan_req ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.rd_en      = 1'b1;
        cmd.scan_clear = (cnt_r == '0);
        if (cnt_r == msat_pkg::SLOT_IDX_W'(msat_pkg::SLOT_COUNT - 1)) begin
          state_nxt = S_TAIL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // last slot is evaluated here
      S_TAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### design/msat_dp.sv
`default_nettype none

module msat_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_operation,
  input  wire logic [30:0]        in_now,
  input  wire logic signed [31:0] in_delay_seconds,
  input  wire logic [15:0]        in_alarm_tag,
  input  wire logic               cfg_we,
  input  wire logic [30:0]        cfg_max_delay_seconds,
  input  wire msat_pkg::ctl_cmd_t cmd,
  output msat_pkg::dp_sts_t       sts,
  output logic [1:0]              out_status,
  output logic                    out_triggered,
  output logic [15:0]             out_ring_tag,
  output logic                    out_ring_active,
  output logic [3:0]              out_slot_used,
  output logic [3:0]              out_active_count,
  output logic [15:0]             out_next_tag,
  output logic [30:0]             out_next_time
);

  localparam int N  = msat_pkg::SLOT_COUNT;
  localparam int IW = msat_pkg::SLOT_IDX_W;
  localparam int TW = msat_pkg::TAG_BITS;
  localparam int CNT_W_L = msat_pkg::CNT_W;

  logic [1:0]    op_r;
  logic [30:0]   now_r;
  logic [31:0]   delay_r;
  logic [TW-1:0] tag_r;
  logic [30:0]   max_delay_r;

  logic [N-1:0]  occ_r;
  logic [TW-1:0] tag_mem [N];
  logic [30:0]   time_mem [N];

  logic [TW-1:0] earliest_tag_r;
  logic [30:0]   earliest_time_r;
  logic          ring_r;
  logic          found_r;

  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_trig_r, res_trig_nxt;
  logic [TW-1:0] res_ring_tag_r, res_ring_tag_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;

  logic          rd_valid_r;
  logic [IW-1:0] rd_idx_r;
  logic [TW-1:0] rd_tag_r;
  logic [30:0]   rd_time_r;

  logic          delay_bad;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   sum;
  logic [30:0]   expiry;
  logic          due;
  logic [CNT_W_L-1:0] occ_cnt;

  assign delay_bad = delay_r[31] || (delay_r == '0) || (delay_r[30:0] > max_delay_r);
  assign sum       = {1'b0, now_r} + {1'b0, delay_r[30:0]};
  assign expiry    = sum[31] ? msat_pkg::TIME_MAX : sum[30:0];
  assign due       = (earliest_tag_r != '0) && (earliest_time_r != '0) &&
                     (now_r >= earliest_time_r);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    occ_cnt = '0;
    for (int i = 0; i < N; i++) begin
      occ_cnt = occ_cnt + CNT_W_L'(occ_r[i]);
    end
  end

  assign sts.scan_req = ((op_r == msat_pkg::OP_TICK) && due) ||
                        ((op_r == msat_pkg::OP_SET) && !delay_bad && free_found);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_operation;
      now_r   <= in_now;
      delay_r <= $unsigned(in_delay_seconds);
      tag_r   <= msat_pkg::tag_in(in_alarm_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r <= msat_pkg::DEFAULT_MAX_DELAY;
    end else if (cfg_we) begin
      max_delay_r <= cfg_max_delay_seconds;
    end
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == msat_pkg::OP_SET) && !delay_bad && free_found &&
        (tag_r != '0)) begin
      tag_mem[free_idx]  <= tag_r;
      time_mem[free_idx] <= expiry;
    end
    if (cmd.rd_en) begin
      rd_tag_r  <= tag_mem[cmd.rd_addr];
      rd_time_r <= time_mem[cmd.rd_addr];
    end
    rd_idx_r <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
    end
  end

  always_comb begin
    res_status_nxt   = msat_pkg::ST_OK;
    res_trig_nxt     = 1'b0;
    res_ring_tag_nxt = '0;
    res_slot_nxt     = '0;
    unique case (op_r)
      msat_pkg::OP_TICK: begin
        if (due) begin
          res_trig_nxt     = 1'b1;
          res_ring_tag_nxt = earliest_tag_r;
        end
      end
      msat_pkg::OP_SET: begin
        if (delay_bad) begin
          res_status_nxt = msat_pkg::ST_BAD_DELAY;
        end else if (!free_found) begin
          res_status_nxt = msat_pkg::ST_FULL;
        end else begin
          res_slot_nxt = free_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r   <= res_status_nxt;
      res_trig_r     <= res_trig_nxt;
      res_ring_tag_r <= res_ring_tag_nxt;
      res_slot_r     <= res_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r           <= '0;
      earliest_tag_r  <= '0;
      earliest_time_r <= '0;
      ring_r          <= 1'b0;
      found_r         <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (op_r)
          msat_pkg::OP_TICK: begin
            if (due) begin
              ring_r <= 1'b1;
            end
          end
          msat_pkg::OP_SET: begin
            // a zero tag leaves the slot free
            if (!delay_bad && free_found && (tag_r != '0)) begin
              occ_r[free_idx] <= 1'b1;
            end
          end
          msat_pkg::OP_CLEAR: begin
            ring_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_clear) begin
        earliest_tag_r  <= '0;
        earliest_time_r <= '0;
        found_r         <= 1'b0;
      end
      if (rd_valid_r && occ_r[rd_idx_r]) begin
        if ((rd_time_r == '0) || (rd_time_r <= now_r)) begin
          occ_r[rd_idx_r] <= 1'b0;
        end else if (!found_r || (rd_time_r < earliest_time_r)) begin
          earliest_tag_r  <= rd_tag_r;
          earliest_time_r <= rd_time_r;
          found_r         <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= res_status_r;
      out_triggered    <= res_trig_r;
      out_ring_tag     <= msat_pkg::tag_out(res_ring_tag_r);
      out_ring_active  <= ring_r;
      out_slot_used    <= 4'(res_slot_r);
      out_active_count <= 4'(occ_cnt);
      out_next_tag     <= msat_pkg::tag_out(earliest_tag_r);
      out_next_time    <= earliest_time_r;
    end
  end

endmodule

`default_nettype wire

### design/multi_slot_alarm_table.sv
// channel  | ports                                    | dir | handshake
// ---------+------------------------------------------+-----+--------------------
// input    | in_operation, in_now, in_delay_seconds,   | in  | in_valid / in_ready
//          | in_alarm_tag                             |     |
// result   | out_status .. out_next_time (8 fields)   | out | out_valid / out_ready
// config   | cfg_max_delay_seconds                    | in  | cfg_valid / cfg_ready
//
// an item skips the rescan (tick not due, clear, unused op, rejected set) or has the
// slot table rescanned one slot per cycle through its single read port; a stalled
// result beat holds the item in its last state until the result is taken.
// synchronous active-low reset empties the table, drops the ring flag and loads
// the default max delay. the next beat is taken while a result still waits.
`default_nettype none

module multi_slot_alarm_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [30:0]        in_now,
  input  wire logic signed [31:0] in_delay_seconds,
  input  wire logic [15:0]        in_alarm_tag,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic                    out_triggered,
  output logic [15:0]             out_ring_tag,
  output logic                    out_ring_active,
  output logic [3:0]              out_slot_used,
  output logic [3:0]              out_active_count,
  output logic [15:0]             out_next_tag,
  output logic [30:0]             out_next_time,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_max_delay_seconds
);

  msat_pkg::ctl_cmd_t cmd;
  msat_pkg::dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  msat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msat_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_operation          (in_operation),
    .in_now                (in_now),
    .in_delay_seconds      (in_delay_seconds),
    .in_alarm_tag          (in_alarm_tag),
    .cfg_we                (cfg_valid),
    .cfg_max_delay_seconds (cfg_max_delay_seconds),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_status            (out_status),
    .out_triggered         (out_triggered),
    .out_ring_tag          (out_ring_tag),
    .out_ring_active       (out_ring_active),
    .out_slot_used         (out_slot_used),
    .out_active_count      (out_active_count),
    .out_next_tag          (out_next_tag),
    .out_next_time         (out_next_time)
  );

endmodule

`default_nettype wire

### dv/alarm_table_checker.sv
`timescale 1ns / 1ps

module alarm_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [30:0]        in_now,
  input  logic signed [31:0] in_delay_seconds,
  input  logic [15:0]        in_alarm_tag,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic               out_triggered,
  input  logic [15:0]        out_ring_tag,
  input  logic               out_ring_active,
  input  logic [3:0]         out_slot_used,
  input  logic [3:0]         out_active_count,
  input  logic [15:0]        out_next_tag,
  input  logic [30:0]        out_next_time,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [30:0]        cfg_max_delay_seconds,
  output int                 mismatch_total,
  output int                 results_outstanding
);

  localparam logic [15:0] TAG_MASK = 16'((33'd1 << msat_pkg::TAG_BITS) - 33'd1);

  typedef struct packed {
    logic [1:0]  status;
    logic        triggered;
    logic [15:0] ring_tag;
    logic        ring_active;
    logic [3:0]  slot_used;
    logic [3:0]  active_count;
    logic [15:0] next_tag;
    logic [30:0] next_time;
  } alarm_result_t;

  logic [15:0]   slot_tag    [msat_pkg::SLOT_COUNT];
  logic [30:0]   slot_expiry [msat_pkg::SLOT_COUNT];
  logic [15:0]   soonest_tag;
  logic [30:0]   soonest_time;
  logic          ringing;
  logic [30:0]   delay_limit;
  alarm_result_t expected_results [$];
  int            mismatch_tally = 0;

  task automatic note_failure(input string msg);
    $display("[%0t] alarm table check: %s", $time, msg);
    mismatch_tally++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) note_failure($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // drops expired slots and recaches the earliest alarm, lowest slot wins ties
  function automatic void sweep_slots(input logic [30:0] now);
    bit found;
    found        = 1'b0;
    soonest_tag  = '0;
    soonest_time = '0;
    for (int i = 0; i < msat_pkg::SLOT_COUNT; i++) begin
      if (slot_tag[i] == '0) continue;
      if (slot_expiry[i] == '0 || slot_expiry[i] <= now) begin
        slot_tag[i]    = '0;
        slot_expiry[i] = '0;
      end else if (!found || slot_expiry[i] < soonest_time) begin
        soonest_tag  = slot_tag[i];
        soonest_time = slot_expiry[i];
        found        = 1'b1;
      end
    end
  endfunction

  function automatic alarm_result_t apply_alarm_op(input logic [1:0] op,
                                                   input logic [30:0] now,
                                                   input logic signed [31:0] delay,
                                                   input logic [15:0] tag);
    alarm_result_t r;
    int            free_slot;
    logic [31:0]   expiry_sum;
    logic [30:0]   expiry;
    logic [15:0]   tag_kept;
    r        = '0;
    tag_kept = tag & TAG_MASK;
    case (op)
      msat_pkg::OP_TICK: begin
        if (soonest_tag != '0 && soonest_time != '0 && now >= soonest_time) begin
          ringing     = 1'b1;
          r.triggered = 1'b1;
          r.ring_tag  = soonest_tag;
          sweep_slots(now);
        end
      end
      msat_pkg::OP_SET: begin
        if (delay[31] || delay == 0 || delay[30:0] > delay_limit) begin
          r.status = msat_pkg::ST_BAD_DELAY;
        end else begin
          free_slot = -1;
          for (int i = 0; i < msat_pkg::SLOT_COUNT; i++)
            if (slot_tag[i] == '0 && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            r.status = msat_pkg::ST_FULL;
          end else begin
            expiry_sum = {1'b0, now} + {1'b0, delay[30:0]};
            expiry     = (expiry_sum > {1'b0, msat_pkg::TIME_MAX}) ?
                         msat_pkg::TIME_MAX : expiry_sum[30:0];
            slot_tag[free_slot]    = tag_kept;
            slot_expiry[free_slot] = (tag_kept != '0) ? expiry : '0;
            r.slot_used            = 4'(free_slot);
            sweep_slots(now);
          end
        end
      end
      msat_pkg::OP_CLEAR: ringing = 1'b0;
      default: ;
    endcase
    for (int i = 0; i < msat_pkg::SLOT_COUNT; i++)
      if (slot_tag[i] != '0 && slot_expiry[i] != '0) r.active_count++;
    r.ring_active = ringing;
    r.next_tag    = soonest_tag;
    r.next_time   = soonest_time;
    return r;
  endfunction

  task automatic compare_result(input alarm_result_t seen, input alarm_result_t want);
    compare_field("status", seen.status, want.status);
    compare_field("triggered", seen.triggered, want.triggered);
    compare_field("ring_tag", seen.ring_tag, want.ring_tag);
    compare_field("ring_active", seen.ring_active, want.ring_active);
    compare_field("slot_used", seen.slot_used, want.slot_used);
    compare_field("active_count", seen.active_count, want.active_count);
    compare_field("next_tag", seen.next_tag, want.next_tag);
    compare_field("next_time", seen.next_time, want.next_time);
  endtask

  always @(posedge clk) begin
    alarm_result_t seen;
    if (!rst_n) begin
      for (int i = 0; i < msat_pkg::SLOT_COUNT; i++) begin
        slot_tag[i]    = '0;
        slot_expiry[i] = '0;
      end
      soonest_tag  = '0;
      soonest_time = '0;
      ringing      = 1'b0;
      delay_limit  = msat_pkg::DEFAULT_MAX_DELAY;
      expected_results.delete();
    end else begin
      // result beats are checked before this edge's input beat is predicted
      if (out_valid && out_ready) begin
        seen = '{out_status, out_triggered, out_ring_tag, out_ring_active,
                 out_slot_used, out_active_count, out_next_tag, out_next_time};
        if (expected_results.size() == 0)
          note_failure($sformatf("result beat with nothing expected, next_tag %0d",
                                 out_next_tag));
        else
          compare_result(seen, expected_results.pop_front());
      end
      if (cfg_valid && cfg_ready) delay_limit = cfg_max_delay_seconds;
      if (in_valid && in_ready)
        expected_results.push_back(apply_alarm_op(in_operation, in_now,
                                                  in_delay_seconds, in_alarm_tag));
    end
    results_outstanding <= expected_results.size();
    mismatch_total      <= mismatch_tally;
  end

endmodule

### dv/tb_multi_slot_alarm_table.sv
`timescale 1ns / 1ps

module tb_multi_slot_alarm_table;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF       = 6;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_PAD     = 20;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int PHASES         = 7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic [30:0]        in_now;
  logic signed [31:0] in_delay_seconds;
  logic [15:0]        in_alarm_tag;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic               out_triggered;
  logic [15:0]        out_ring_tag;
  logic               out_ring_active;
  logic [3:0]         out_slot_used;
  logic [3:0]         out_active_count;
  logic [15:0]        out_next_tag;
  logic [30:0]        out_next_time;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [30:0]        cfg_max_delay_seconds;

  int          mismatch_total;
  int          results_outstanding;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_requests = 0;
  logic [30:0] clock_now = '0;
  logic [30:0] delay_cap = msat_pkg::DEFAULT_MAX_DELAY;

  always #(CLK_HALF) clk = ~clk;

  multi_slot_alarm_table u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_now                (in_now),
    .in_delay_seconds      (in_delay_seconds),
    .in_alarm_tag          (in_alarm_tag),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_triggered         (out_triggered),
    .out_ring_tag          (out_ring_tag),
    .out_ring_active       (out_ring_active),
    .out_slot_used         (out_slot_used),
    .out_active_count      (out_active_count),
    .out_next_tag          (out_next_tag),
    .out_next_time         (out_next_time),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_delay_seconds (cfg_max_delay_seconds)
  );

  alarm_table_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_now                (in_now),
    .in_delay_seconds      (in_delay_seconds),
    .in_alarm_tag          (in_alarm_tag),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_triggered         (out_triggered),
    .out_ring_tag          (out_ring_tag),
    .out_ring_active       (out_ring_active),
    .out_slot_used         (out_slot_used),
    .out_active_count      (out_active_count),
    .out_next_tag          (out_next_tag),
    .out_next_time         (out_next_time),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_delay_seconds (cfg_max_delay_seconds),
    .mismatch_total        (mismatch_total),
    .results_outstanding   (results_outstanding)
  );

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_requests != holds_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic offer_item(input logic [1:0] op, input logic [30:0] now,
                            input logic signed [31:0] delay, input logic [15:0] tag);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_now           <= now;
    in_delay_seconds <= delay;
    in_alarm_tag     <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result has been taken
  task automatic settle_table();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic write_delay_limit(input logic [30:0] limit);
    settle_table();
    cfg_valid             <= 1'b1;
    cfg_max_delay_seconds <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    delay_cap = limit;
  endtask

  task automatic random_alarm_item();
    int                 pick;
    logic [1:0]         op;
    logic signed [31:0] delay;
    logic [15:0]        tag;
    int unsigned        span;
    pick = $urandom_range(99);
    if (pick < 45) op = msat_pkg::OP_SET;
    else if (pick < 85) op = msat_pkg::OP_TICK;
    else if (pick < 97) op = msat_pkg::OP_CLEAR;
    else op = OP_UNUSED;
    // time mostly creeps forward so that pending alarms come due
    pick = $urandom_range(99);
    if (pick < 3) clock_now = 31'($urandom);
    else if (pick < 5) clock_now = msat_pkg::TIME_MAX - 31'($urandom_range(40));
    else if (clock_now < msat_pkg::TIME_MAX - 31'd100)
      clock_now += 31'($urandom_range(40));
    span = (delay_cap == '0) ? 1 : ((delay_cap < 31'd200) ? delay_cap : 200);
    pick = $urandom_range(99);
    if (pick < 80) delay = 32'($urandom_range(1, span));
    else if (pick < 86) delay = {1'b0, delay_cap};
    else if (pick < 90) delay = {1'b0, delay_cap} + 32'd1;
    else delay = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) tag = '0;
    else if (pick < 15) tag = 16'($urandom_range(1, 15));
    else tag = 16'($urandom_range(1, 65535));
    offer_item(op, clock_now, delay, tag);
  endtask

  initial begin
    logic [30:0] cap_plan   [PHASES];
    int          count_plan [PHASES];
    int          guard;
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_operation          = msat_pkg::OP_TICK;
    in_now                = '0;
    in_delay_seconds      = '0;
    in_alarm_tag          = '0;
    cfg_valid             = 1'b0;
    cfg_max_delay_seconds = '0;
    cap_plan   = '{msat_pkg::DEFAULT_MAX_DELAY, 31'd1, msat_pkg::TIME_MAX, 31'd0,
                   31'd1000, 31'($urandom_range(2, 2147483646)), 31'd100};
    count_plan = '{220, 220, 200, 20, 220, 200, 200};
    tx_idle_pct = 16;
    rx_idle_pct = 77;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, register at its reset value
    offer_item(msat_pkg::OP_TICK, 31'd0, 32'sd0, 16'h0000);
    offer_item(msat_pkg::OP_SET, 31'd100, 32'sd0, 16'h0005);
    offer_item(msat_pkg::OP_SET, 31'd100, -32'sd1, 16'h0005);
    offer_item(msat_pkg::OP_SET, 31'd100, 32'sh8000_0000, 16'h0005);
    offer_item(msat_pkg::OP_SET, 31'd100, {1'b0, msat_pkg::DEFAULT_MAX_DELAY} + 32'd1,
               16'h0005);
    offer_item(msat_pkg::OP_SET, 31'd100, {1'b0, msat_pkg::DEFAULT_MAX_DELAY}, 16'hFFFF);
    offer_item(msat_pkg::OP_SET, 31'd100, 32'sd1, 16'h0001);
    offer_item(msat_pkg::OP_SET, 31'd100, 32'sd50, 16'h0000);
    offer_item(msat_pkg::OP_TICK, 31'd100, 32'sd0, 16'h0000);
    offer_item(msat_pkg::OP_TICK, 31'd101, 32'sd0, 16'h0000);
    offer_item(OP_UNUSED, 31'h2AAA_AAAA, 32'sh5555_5555, 16'hAAAA);
    offer_item(msat_pkg::OP_CLEAR, 31'd200, 32'sd0, 16'h0000);
    // expiry saturates: freed at once when now is already at the top
    offer_item(msat_pkg::OP_SET, msat_pkg::TIME_MAX, 32'sd5, 16'hAAAA);
    offer_item(msat_pkg::OP_SET, msat_pkg::TIME_MAX - 31'd3, 32'sd10, 16'h5555);
    for (int i = 0; i < msat_pkg::SLOT_COUNT - 1; i++)
      offer_item(msat_pkg::OP_SET, 31'd1000, 32'(i + 1), 16'h0100 + 16'(i));
    offer_item(msat_pkg::OP_SET, 31'd1000, 32'sd7, 16'h0BAD);
    offer_item(msat_pkg::OP_SET, 31'd1000, 32'sd0, 16'h0BAD);
    offer_item(msat_pkg::OP_TICK, msat_pkg::TIME_MAX, 32'sd0, 16'h0000);
    offer_item(msat_pkg::OP_CLEAR, 31'd0, 32'sd0, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 77;
      end else if (p < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_delay_limit(cap_plan[p]);
      // long receiver hold-off while items keep coming, so the input backs up
      if (p == 2 || p == 5) rx_hold_requests <= rx_hold_requests + 1;
      for (int n = 0; n < count_plan[p]; n++) begin
        if (n == count_plan[p] / 2) settle_table();
        random_alarm_item();
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (results_outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_PAD * 2) @(posedge clk);
    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("[multi_slot_alarm_table] OK");
    end else begin
      $display("[multi_slot_alarm_table] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[multi_slot_alarm_table] ERROR");
    $finish;
  end

endmodule

### filelist.f
design/msat_pkg.sv
design/msat_ctrl.sv
design/msat_dp.sv
design/multi_slot_alarm_table.sv
dv/alarm_table_checker.sv
dv/tb_multi_slot_alarm_table.sv
